// ===== rtl/core/qer_pkg.sv =====
`default_nettype none

package qer_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_COEF_SQUARE = 2'd0;
    localparam logic [1:0] REG_COEF_LINEAR = 2'd1;
    localparam logic [1:0] REG_COEF_CONST  = 2'd2;

    // Number of real roots, from the sign of the discriminant.
    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2
    } qer_cnt_t;

    // Status that travels with an item down the whole pipeline.
    typedef struct packed {
        qer_cnt_t cnt;
        logic     ovf;
        logic     err;
        logic     roots_en;
    } qer_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/qer_front.sv =====
`default_nettype none

module qer_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_vld,
    input  wire logic signed [W-1:0]       x,
    input  wire logic signed [W-1:0]       coef_a,
    input  wire logic signed [W-1:0]       coef_b,
    input  wire logic signed [W-1:0]       coef_c,
    output logic                           out_vld,
    output logic [2*(W+F+1)-1:0]           rad,
    output logic signed [W+F+2:0]          nb,
    output logic signed [W-1:0]            a_out,
    output logic signed [W-1:0]            poly,
    output qer_pkg::qer_flags_t            flags
);
    import qer_pkg::*;

    localparam int W2 = 2 * W;
    localparam int PW = 3 * W + 3;
    localparam int SN = W + F + 3;
    localparam int VB = 2 * (W + F + 1);
    localparam int DB = W2 + 3;

    localparam logic signed [PW-1:0] P_HALF = {{(PW-1){1'b0}}, 1'b1} << (2 * F - 1);
    localparam logic signed [PW-1:0] P_MAX  = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN  = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic [3:0] vld_reg;

    // Stage one: the four single-width products.
    logic signed [W2-1:0] ax_reg, bx1_reg, bb_reg, ac_reg;
    logic signed [W-1:0]  x1_reg, a1_reg, b1_reg, c1_reg;
    // Stage two: a*x*x in two halves and the discriminant.
    logic signed [W2:0]   axx_lo_reg;
    logic signed [W2-1:0] axx_hi_reg, bx2_reg;
    logic signed [DB-1:0] disc2_reg;
    logic signed [W-1:0]  a2_reg, b2_reg, c2_reg;
    // Stage three: the exact polynomial sum and the root setup.
    logic signed [PW-1:0] psum3_reg;
    logic signed [DB-1:0] disc3_reg;
    logic signed [SN-1:0] nb3_reg;
    logic signed [W-1:0]  a3_reg;
    qer_flags_t           flags3_reg;
    // Stage four: outputs.
    logic [VB-1:0]        rad4_reg;
    logic signed [SN-1:0] nb4_reg;
    logic signed [W-1:0]  a4_reg, poly4_reg;
    qer_flags_t           flags4_reg;

    logic signed [PW-1:0] psum_next, psh;
    qer_flags_t           flags3_next, flags4_next;
    logic signed [W-1:0]  poly_next;

    always_comb
    begin
        psum_next = (PW'(axx_hi_reg) <<< W) + PW'(axx_lo_reg)
                  + (PW'(bx2_reg) <<< F) + (PW'(c2_reg) <<< (2 * F)) + P_HALF;

        flags3_next.ovf      = 1'b0;
        flags3_next.err      = (a2_reg == '0);
        flags3_next.roots_en = (a2_reg != '0) && !disc2_reg[DB-1];
        if (disc2_reg[DB-1])
        begin
            flags3_next.cnt = CNT_NONE;
        end
        else if (disc2_reg == '0)
        begin
            flags3_next.cnt = CNT_ONE;
        end
        else
        begin
            flags3_next.cnt = CNT_TWO;
        end

        psh         = psum3_reg >>> (2 * F);
        flags4_next = flags3_reg;
        if (psh > P_MAX)
        begin
            poly_next       = {1'b0, {(W-1){1'b1}}};
            flags4_next.ovf = 1'b1;
        end
        else if (psh < P_MIN)
        begin
            poly_next       = {1'b1, {(W-1){1'b0}}};
            flags4_next.ovf = 1'b1;
        end
        else
        begin
            poly_next = psh[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= W2'(coef_a) * W2'(x);
            bx1_reg <= W2'(coef_b) * W2'(x);
            bb_reg  <= W2'(coef_b) * W2'(coef_b);
            ac_reg  <= W2'(coef_a) * W2'(coef_c);
            x1_reg  <= x;
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            c1_reg  <= coef_c;

            axx_lo_reg <= (W2+1)'($signed({1'b0, ax_reg[W-1:0]})) * (W2+1)'(x1_reg);
            axx_hi_reg <= W2'($signed(ax_reg[W2-1:W])) * W2'(x1_reg);
            disc2_reg  <= DB'(bb_reg) - (DB'(ac_reg) <<< 2);
            bx2_reg    <= bx1_reg;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            c2_reg     <= c1_reg;

            psum3_reg  <= psum_next;
            disc3_reg  <= disc2_reg;
            nb3_reg    <= -(SN'(b2_reg) <<< F);
            a3_reg     <= a2_reg;
            flags3_reg <= flags3_next;

            // A negative discriminant feeds zero; its roots are dropped later.
            rad4_reg   <= flags3_reg.roots_en ?
                          VB'({disc3_reg[W2:0], {(2*F){1'b0}}}) : '0;
            nb4_reg    <= nb3_reg;
            a4_reg     <= a3_reg;
            poly4_reg  <= poly_next;
            flags4_reg <= flags4_next;
        end
    end

    assign out_vld = vld_reg[3];
    assign rad     = rad4_reg;
    assign nb      = nb4_reg;
    assign a_out   = a4_reg;
    assign poly    = poly4_reg;
    assign flags   = flags4_reg;

endmodule

`default_nettype wire

// ===== rtl/core/qer_sqrt_cell.sv =====
`default_nettype none

module qer_sqrt_cell #(
    parameter int RB     = 49,
    parameter int SIDE_W = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                vld_in,
    input  wire logic [2*RB-1:0]     rad_in,
    input  wire logic [RB:0]         rem_in,
    input  wire logic [RB-1:0]       root_in,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     vld_out,
    output logic [2*RB-1:0]          rad_out,
    output logic [RB:0]              rem_out,
    output logic [RB-1:0]            root_out,
    output logic [SIDE_W-1:0]        side_out
);
    localparam int RW = RB + 3;

    logic              vld_reg;
    logic [2*RB-1:0]   rad_reg;
    logic [RB:0]       rem_reg;
    logic [RB-1:0]     root_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [RW-1:0]     rem2, trial, rem_dif;
    logic              ge;

    // One root bit per cell: bring down two radicand bits, try root*4+1.
    always_comb
    begin
        rem2    = {rem_in, rad_in[2*RB-1 -: 2]};
        trial   = RW'({root_in, 2'b01});
        ge      = (rem2 >= trial);
        rem_dif = ge ? (rem2 - trial) : rem2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= rad_in << 2;
            rem_reg  <= rem_dif[RB:0];
            root_reg <= {root_in[RB-2:0], ge};
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/qer_div_cell.sv =====
`default_nettype none

module qer_div_cell #(
    parameter int DW     = 33,
    parameter int NB     = 50,
    parameter int SIDE_W = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic                    vld_in,
    input  wire logic [DW-1:0]           den_in,
    input  wire logic [1:0][NB-1:0]      num_in,
    input  wire logic [1:0][DW-1:0]      rem_in,
    input  wire logic [1:0][NB-1:0]      quo_in,
    input  wire logic [SIDE_W-1:0]       side_in,
    output logic                         vld_out,
    output logic [DW-1:0]                den_out,
    output logic [1:0][NB-1:0]           num_out,
    output logic [1:0][DW-1:0]           rem_out,
    output logic [1:0][NB-1:0]           quo_out,
    output logic [SIDE_W-1:0]            side_out
);
    logic                 vld_reg;
    logic [DW-1:0]        den_reg;
    logic [1:0][NB-1:0]   num_reg, quo_reg;
    logic [1:0][DW-1:0]   rem_reg, rem_nx;
    logic [SIDE_W-1:0]    side_reg;
    logic [1:0][DW:0]     r2;
    logic [1:0]           ge;

    // Restoring division, one quotient bit per cell for both roots.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            r2[i]     = {rem_in[i], num_in[i][NB-1]};
            ge[i]     = (r2[i] >= {1'b0, den_in});
            rem_nx[i] = ge[i] ? DW'(r2[i] - {1'b0, den_in}) : DW'(r2[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg  <= den_in;
            side_reg <= side_in;
            rem_reg  <= rem_nx;
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= num_in[i] << 1;
                quo_reg[i] <= {quo_in[i][NB-2:0], ge[i]};
            end
        end
    end

    assign vld_out  = vld_reg;
    assign den_out  = den_reg;
    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/quadratic_eval_and_roots_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// x         in         x_valid / x_stall         sample_x
// res       out        res_valid / res_stall     poly_value, root_count, root_low,
//                                                root_high, overflow_flag, coef_error
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The unit takes one item per clock while x_stall is low and gives one result
// per item, in order. Items pass through the front, the square-root chain (one
// cell per root bit), the root setup registers, the divider chain (one cell per
// quotient bit, both roots side by side) and the output register.
// Reset loads the coefficients with a = 1.0, b = 0, c = 0 and empties the pipeline.
// The pipeline holds only when a result waits in the output register under stall
// and another finished item stands right behind it; bubbles still close up.

module quadratic_eval_and_roots_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          x_valid,
    output logic                               x_stall,
    input  wire logic signed [WORD_BITS-1:0]   sample_x,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic signed [WORD_BITS-1:0]        poly_value,
    output logic [1:0]                         root_count,
    output logic signed [WORD_BITS-1:0]        root_low,
    output logic signed [WORD_BITS-1:0]        root_high,
    output logic                               overflow_flag,
    output logic                               coef_error,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [WORD_BITS-1:0]          cfg_data
);
    import qer_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int R  = W + F + 1;       // square-root bits
    localparam int VB = 2 * R;           // radicand bits
    localparam int N  = W + F + 2;       // dividend and quotient bits
    localparam int SN = W + F + 3;       // signed numerator bits
    localparam int DW = W + 1;           // divisor bits
    localparam int FW = $bits(qer_flags_t);
    localparam int SQ_SIDE_W = FW + W + W + SN;
    localparam int DV_SIDE_W = FW + W + 2;

    localparam logic [N-1:0] Q_MAX    = {{(N-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [N-1:0] Q_MINMAG = {{(N-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    // Coefficient registers.
    logic signed [W-1:0] coef_square_reg, coef_linear_reg, coef_const_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_square_reg <= W'(1) << F;
            coef_linear_reg <= '0;
            coef_const_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_SQUARE: coef_square_reg <= cfg_data;
                REG_COEF_LINEAR: coef_linear_reg <= cfg_data;
                REG_COEF_CONST:  coef_const_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Global advance: the whole pipeline moves unless a finished item would
    // run into a result that is still held in the output register.
    logic adv;
    logic div_last_vld;
    logic res_valid_reg;

    assign adv     = !(res_valid_reg && res_stall && div_last_vld);
    assign x_stall = !adv;

    // Front: products, polynomial value and discriminant.
    logic                 fr_vld;
    logic [VB-1:0]        fr_rad;
    logic signed [SN-1:0] fr_nb;
    logic signed [W-1:0]  fr_a, fr_poly;
    qer_flags_t           fr_flags;

    qer_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (x_valid),
        .x      (sample_x),
        .coef_a (coef_square_reg),
        .coef_b (coef_linear_reg),
        .coef_c (coef_const_reg),
        .out_vld(fr_vld),
        .rad    (fr_rad),
        .nb     (fr_nb),
        .a_out  (fr_a),
        .poly   (fr_poly),
        .flags  (fr_flags)
    );

    // Square-root chain: cell k settles root bit R-1-k.
    logic                 sq_vld  [R+1];
    logic [VB-1:0]        sq_rad  [R+1];
    logic [R:0]           sq_rem  [R+1];
    logic [R-1:0]         sq_root [R+1];
    logic [SQ_SIDE_W-1:0] sq_side [R+1];

    assign sq_vld[0]  = fr_vld;
    assign sq_rad[0]  = fr_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {fr_flags, fr_poly, fr_a, fr_nb};

    for (genvar k = 0; k < R; k++)
    begin : g_sqrt
        qer_sqrt_cell #(
            .RB    (R),
            .SIDE_W(SQ_SIDE_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (sq_vld[k]),
            .rad_in  (sq_rad[k]),
            .rem_in  (sq_rem[k]),
            .root_in (sq_root[k]),
            .side_in (sq_side[k]),
            .vld_out (sq_vld[k+1]),
            .rad_out (sq_rad[k+1]),
            .rem_out (sq_rem[k+1]),
            .root_out(sq_root[k+1]),
            .side_out(sq_side[k+1])
        );
    end

    // Root setup, first step: fold the sign of a into the numerators and add
    // |a| so that a floor division by 2|a| rounds half up.
    qer_flags_t           sq_flags;
    logic signed [W-1:0]  sq_poly, sq_a;
    logic signed [SN-1:0] sq_nb, s_ext, a_ext, aa;
    logic                 aneg;

    assign {sq_flags, sq_poly, sq_a, sq_nb} = sq_side[R];
    assign aneg  = sq_a[W-1];
    assign s_ext = SN'(sq_root[R]);
    assign a_ext = SN'(sq_a);
    assign aa    = aneg ? -a_ext : a_ext;

    logic                 p1_vld_reg, p2_vld_reg;
    logic signed [SN-1:0] p1_num_lo_reg, p1_num_hi_reg;
    logic [DW-1:0]        p1_den_reg, p2_den_reg;
    logic signed [W-1:0]  p1_poly_reg, p2_poly_reg;
    qer_flags_t           p1_flags_reg, p2_flags_reg;
    logic [1:0][N-1:0]    p2_mag_reg;
    logic [1:0]           p2_neg_reg;
    logic signed [SN-1:0] mag_lo, mag_hi;

    // Second step: a negative numerator becomes a ceiling on its magnitude.
    assign mag_lo = p1_num_lo_reg[SN-1] ?
                    (SN'(p1_den_reg) - SN'(1) - p1_num_lo_reg) : p1_num_lo_reg;
    assign mag_hi = p1_num_hi_reg[SN-1] ?
                    (SN'(p1_den_reg) - SN'(1) - p1_num_hi_reg) : p1_num_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= sq_vld[R];
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_num_lo_reg <= (aneg ? (s_ext - sq_nb) : (sq_nb - s_ext)) + aa;
            p1_num_hi_reg <= (aneg ? (-sq_nb - s_ext) : (sq_nb + s_ext)) + aa;
            p1_den_reg    <= {aa[W-1:0], 1'b0};
            p1_poly_reg   <= sq_poly;
            p1_flags_reg  <= sq_flags;

            p2_mag_reg[0] <= mag_lo[N-1:0];
            p2_mag_reg[1] <= mag_hi[N-1:0];
            p2_neg_reg    <= {p1_num_hi_reg[SN-1], p1_num_lo_reg[SN-1]};
            p2_den_reg    <= p1_den_reg;
            p2_poly_reg   <= p1_poly_reg;
            p2_flags_reg  <= p1_flags_reg;
        end
    end

    // Divider chain: both roots divided by 2|a|, one quotient bit per cell.
    logic                 dv_vld  [N+1];
    logic [DW-1:0]        dv_den  [N+1];
    logic [1:0][N-1:0]    dv_num  [N+1];
    logic [1:0][DW-1:0]   dv_rem  [N+1];
    logic [1:0][N-1:0]    dv_quo  [N+1];
    logic [DV_SIDE_W-1:0] dv_side [N+1];

    assign dv_vld[0]  = p2_vld_reg;
    assign dv_den[0]  = p2_den_reg;
    assign dv_num[0]  = p2_mag_reg;
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = {p2_flags_reg, p2_poly_reg, p2_neg_reg};

    for (genvar k = 0; k < N; k++)
    begin : g_div
        qer_div_cell #(
            .DW    (DW),
            .NB    (N),
            .SIDE_W(DV_SIDE_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (dv_vld[k]),
            .den_in  (dv_den[k]),
            .num_in  (dv_num[k]),
            .rem_in  (dv_rem[k]),
            .quo_in  (dv_quo[k]),
            .side_in (dv_side[k]),
            .vld_out (dv_vld[k+1]),
            .den_out (dv_den[k+1]),
            .num_out (dv_num[k+1]),
            .rem_out (dv_rem[k+1]),
            .quo_out (dv_quo[k+1]),
            .side_out(dv_side[k+1])
        );
    end

    // Final sign, saturation and output register.
    qer_flags_t          dv_flags;
    logic signed [W-1:0] dv_poly;
    logic [1:0]          dv_neg;
    logic [1:0][W-1:0]   root_sat;
    logic [1:0]          root_ovf;
    logic [N-1:0]        qneg;

    assign div_last_vld = dv_vld[N];
    assign {dv_flags, dv_poly, dv_neg} = dv_side[N];

    always_comb
    begin
        qneg = '0;
        for (int i = 0; i < 2; i++)
        begin
            qneg        = -dv_quo[N][i];
            root_ovf[i] = 1'b0;
            if (!dv_neg[i] && (dv_quo[N][i] > Q_MAX))
            begin
                root_sat[i] = {1'b0, {(W-1){1'b1}}};
                root_ovf[i] = 1'b1;
            end
            else if (dv_neg[i] && (dv_quo[N][i] > Q_MINMAG))
            begin
                root_sat[i] = {1'b1, {(W-1){1'b0}}};
                root_ovf[i] = 1'b1;
            end
            else if (dv_neg[i])
            begin
                root_sat[i] = qneg[W-1:0];
            end
            else
            begin
                root_sat[i] = dv_quo[N][i][W-1:0];
            end
        end
    end

    logic                res_load;
    logic signed [W-1:0] poly_reg, root_low_reg, root_high_reg;
    logic [1:0]          count_reg;
    logic                ovf_reg, err_reg;

    assign res_load = div_last_vld && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            poly_reg      <= dv_poly;
            count_reg     <= dv_flags.cnt;
            err_reg       <= dv_flags.err;
            root_low_reg  <= dv_flags.roots_en ? root_sat[0] : '0;
            root_high_reg <= dv_flags.roots_en ? root_sat[1] : '0;
            ovf_reg       <= dv_flags.ovf || (dv_flags.roots_en && (|root_ovf));
        end
    end

    assign res_valid     = res_valid_reg;
    assign poly_value    = poly_reg;
    assign root_count    = count_reg;
    assign root_low      = root_low_reg;
    assign root_high     = root_high_reg;
    assign overflow_flag = ovf_reg;
    assign coef_error    = err_reg;

    // A zero coefficient a never yields roots.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && coef_error |-> root_low == '0 && root_high == '0)
        else $error("roots reported with zero coefficient a");

    // With a zero a the discriminant is b squared, never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && coef_error |-> root_count != CNT_NONE)
        else $error("zero a reported a negative discriminant");

    // A negative discriminant gives zero roots.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && root_count == CNT_NONE |-> root_low == '0 && root_high == '0)
        else $error("roots reported for a negative discriminant");

    // Input is held off only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        x_stall |-> res_valid && res_stall)
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

// ===== sim/qer_checker.sv =====
`timescale 1ns / 1ps

module qer_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               x_valid,
    input  wire logic               x_stall,
    input  wire logic signed [31:0] sample_x,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire logic signed [31:0] poly_value,
    input  wire logic [1:0]         root_count,
    input  wire logic signed [31:0] root_low,
    input  wire logic signed [31:0] root_high,
    input  wire logic               overflow_flag,
    input  wire logic               coef_error,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      pending
);
    import qer_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [31:0] poly;
        qer_cnt_t           cnt;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               ovf;
        logic               err;
    } solution_t;

    solution_t          solutions_due[$];
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;

    function automatic wide_t floor_sqrt(input wide_t v);
        wide_t r;
        wide_t c;
        r = 0;
        for (int k = 63; k >= 0; k--)
        begin
            c = r | (wide_t'(1) <<< k);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    // Division by 2a, rounded to nearest with ties toward plus infinity.
    function automatic wide_t round_half_div(input wide_t n, input wide_t a);
        wide_t num;
        wide_t den;
        wide_t q;
        if (a < 0)
        begin
            a = -a;
            n = -n;
        end
        den = a * 2;
        num = n + a;
        q = num / den;
        if (num < 0 && q * den != num)
            q = q - 1;
        return q;
    endfunction

    // Returns the clamped word with the saturation flag on top.
    function automatic logic [32:0] clamp_word(input wide_t v);
        if (v > wide_t'(32'sh7fffffff))
            return {1'b1, 32'h7fffffff};
        if (v < wide_t'(-64'sd2147483648))
            return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic solution_t solve_quadratic(input logic signed [31:0] xv);
        solution_t   r;
        wide_t       wa;
        wide_t       wb;
        wide_t       wc;
        wide_t       wx;
        wide_t       p;
        wide_t       d;
        wide_t       s;
        wide_t       nb;
        logic [32:0] sat;
        wa = coef_a;
        wb = coef_b;
        wc = coef_c;
        wx = xv;
        p = wa * wx * wx + ((wb * wx) <<< 16) + (wc <<< 32) + (wide_t'(1) <<< 31);
        p = p >>> 32;
        sat = clamp_word(p);
        r.poly = sat[31:0];
        r.ovf = sat[32];
        d = wb * wb - wa * wc * 4;
        r.cnt = (d < 0) ? CNT_NONE : ((d == 0) ? CNT_ONE : CNT_TWO);
        r.lo = '0;
        r.hi = '0;
        r.err = (coef_a == 0);
        if (!r.err && d >= 0)
        begin
            s = floor_sqrt(d <<< 32);
            nb = (-wb) <<< 16;
            sat = clamp_word(round_half_div(nb - s, wa));
            r.lo = sat[31:0];
            r.ovf |= sat[32];
            sat = clamp_word(round_half_div(nb + s, wa));
            r.hi = sat[31:0];
            r.ovf |= sat[32];
        end
        return r;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = solutions_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        solution_t e;
        if (!rst_n)
        begin
            coef_a = 32'sh00010000;
            coef_b = '0;
            coef_c = '0;
            solutions_due.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (solutions_due.size() == 0)
                begin
                    report("unexpected result", 1, 0);
                end
                else
                begin
                    e = solutions_due.pop_front();
                    if (poly_value != e.poly)
                        report("poly_value", poly_value, e.poly);
                    if (root_count != e.cnt)
                        report("root_count", root_count, e.cnt);
                    if (root_low != e.lo)
                        report("root_low", root_low, e.lo);
                    if (root_high != e.hi)
                        report("root_high", root_high, e.hi);
                    if (overflow_flag != e.ovf)
                        report("overflow_flag", overflow_flag, e.ovf);
                    if (coef_error != e.err)
                        report("coef_error", coef_error, e.err);
                end
            end
            if (x_valid && !x_stall)
                solutions_due.push_back(solve_quadratic(sample_x));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEF_SQUARE: coef_a = cfg_data;
                    REG_COEF_LINEAR: coef_b = cfg_data;
                    REG_COEF_CONST:  coef_c = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Top of the quadratic unit testbench. It drives sample points and coefficient
// writes, idles both channels at random, and gives the verdict. All prediction
// and comparison happens in the checker instantiated beside the block.
module testbench;
    import qer_pkg::*;

    localparam int LATENCY = 106;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 60;

    logic               clk;
    logic               rst_n;
    logic               x_valid;
    logic               x_stall;
    logic signed [31:0] sample_x;
    logic               res_valid;
    logic               res_stall;
    logic signed [31:0] poly_value;
    logic [1:0]         root_count;
    logic signed [31:0] root_low;
    logic signed [31:0] root_high;
    logic               overflow_flag;
    logic               coef_error;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 cycles;

    // Idle level shared with the receiver process: zero means no stalls at all.
    int                 idle_level;
    bit                 hold_request;

    quadratic_eval_and_roots_unit dut (.*);

    qer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        x_valid = 1'b0;
        sample_x = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_COEF_SQUARE;
        cfg_data = '0;
        idle_level = 4;
        hold_request = 1'b0;
        cycles = 0;
    end

    always #1 clk = ~clk;

    // The run is bounded by a plain cycle counter.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Receiver side. It stalls in random bursts, and once, on request, it holds
    // off far longer than the pipeline depth so that the block fills up and
    // pushes back on its input while the sender keeps offering items.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                res_stall <= 1'b1;
                repeat (4 * LATENCY) @(posedge clk);
                res_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (idle_level != 0 && $urandom_range(0, 15) < idle_level)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Offers one sample point and returns once it has been taken. Valid stays high
    // afterwards unless the task then idles at random, so back-to-back items need no gap.
    task automatic send_sample(input logic signed [31:0] xv);
        x_valid <= 1'b1;
        sample_x <= xv;
        do
            @(posedge clk);
        while (x_stall);
        if (idle_level != 0 && $urandom_range(0, 15) < idle_level)
        begin
            x_valid <= 1'b0;
            sample_x <= $urandom;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic write_coef(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        x_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Mostly sample points near the roots of small polynomials, the rest fully random.
    function automatic logic signed [31:0] random_sample();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h00140000)) - 32'sh000a0000;
    endfunction

    function automatic logic [31:0] random_coef();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
    endfunction

    initial
    begin
        logic signed [31:0] corner_x [12];
        logic [31:0]        ca;
        logic [31:0]        cb;
        logic [31:0]        cc;

        corner_x = '{32'sh0, 32'sh1, -32'sh1, 32'sh7fffffff, 32'sh80000000,
                     32'sh00010000, -32'sh00010000, 32'sh00018000, 32'sh00008000,
                     -32'sh00008000, 32'sh0000ffff, 32'sh55555555};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Coefficient sets: the first phase runs on the reset values, which
            // give a double root at zero. The later ones cover two real roots,
            // the word extremes, a zero a, a negative a, no real roots and
            // random sets.
            if (ph != 0)
            begin
                case (ph)
                    1:
                    begin
                        ca = 32'h00010000; cb = 32'h0; cc = 32'hfffc0000;
                    end
                    2:
                    begin
                        ca = 32'h7fffffff; cb = 32'h80000000; cc = 32'h7fffffff;
                    end
                    3:
                    begin
                        ca = 32'h0; cb = 32'h00030000; cc = 32'h00010000;
                    end
                    4:
                    begin
                        ca = 32'hfffe0000; cb = 32'h00010000; cc = 32'h00050000;
                    end
                    5:
                    begin
                        ca = 32'h00010000; cb = 32'h0; cc = 32'h00010000;
                    end
                    6:
                    begin
                        ca = 32'h80000000; cb = 32'h7fffffff; cc = 32'h80000000;
                    end
                    default:
                    begin
                        ca = random_coef();
                        cb = random_coef();
                        cc = random_coef();
                    end
                endcase
                write_coef(REG_COEF_SQUARE, ca);
                write_coef(REG_COEF_LINEAR, cb);
                write_coef(REG_COEF_CONST, cc);
            end

            // Some phases run with no idling at all, including the last one.
            idle_level = (ph == PHASES - 1 || ph == 5) ? 0 : $urandom_range(2, 8);
            if (ph == 3)
                hold_request = 1'b1;

            if (ph < 3)
                foreach (corner_x[i])
                    send_sample(corner_x[i]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(random_sample());

            // The sender pauses here until every result of the phase is back.
            wait_drained();
        end

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
